/* hw/rtl/ctp_pkg.sv */
// Shared widths, sideband types and constants of the circle-through-three-points pipeline.
package ctp_pkg;

  localparam int COORD_W = 20;               // input coordinate width
  localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
  localparam int SQ_W    = 2 * COORD_W;      // square of one coordinate
  localparam int NORM_W  = 2 * COORD_W + 1;  // squared norm and its differences
  localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
  localparam int DET_W   = PROD_W + 1;       // determinant
  localparam int NUMP_W  = NORM_W + DIFF_W;  // product of norm term and difference
  localparam int NUM_W   = NUMP_W + 1;       // centre numerator
  localparam int DEN_W   = DET_W;            // magnitude of twice the determinant
  localparam int DMIN_W  = 41;               // collinearity threshold register
  localparam int OUT_W   = 32;               // centre and radius width
  localparam int ROOT_W  = 2 * OUT_W;        // radicand width
  localparam int IN_W    = 6 * COORD_W;      // packed input item
  localparam int DATA_W  = 3 * OUT_W;        // packed result data

  localparam logic [DMIN_W-1:0] DET_MIN_RST = DMIN_W'(1);
  localparam logic [OUT_W-1:0]  POS_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  NEG_MIN     = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  RAD_MAX     = {OUT_W{1'b1}};

  // Travels alongside the two quotients through the divider.
  typedef struct packed {
    logic                      ok;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } div_side_t;

  // Travels alongside the radicand through the square-root pipeline.
  typedef struct packed {
    logic             ok;
    logic             sat;
    logic             big;
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
  } root_side_t;

endpackage

/* hw/rtl/ctp_front.sv */
// Front pipeline: differences, norms, determinant, numerators and the collinearity test.
module ctp_front import ctp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] x1_i,
  input  logic signed [COORD_W-1:0] y1_i,
  input  logic signed [COORD_W-1:0] x2_i,
  input  logic signed [COORD_W-1:0] y2_i,
  input  logic signed [COORD_W-1:0] x3_i,
  input  logic signed [COORD_W-1:0] y3_i,
  input  logic [DMIN_W-1:0]         det_min_i,
  output logic                      valid_o,
  output logic [NUM_W-1:0]          num_x_o,
  output logic [NUM_W-1:0]          num_y_o,
  output logic [DEN_W-1:0]          den_o,
  output div_side_t                 side_o
);

  // Stage A: differences and squares.
  logic                      a_vld_q;
  logic signed [DIFF_W-1:0]  a_dx12_q, a_dy12_q, a_dx23_q, a_dy23_q;
  logic [SQ_W-1:0]           a_sx1_q, a_sy1_q, a_sx2_q, a_sy2_q, a_sx3_q, a_sy3_q;
  logic signed [COORD_W-1:0] a_x1_q, a_y1_q;
  // Stage B: norm differences and determinant products.
  logic                      b_vld_q;
  logic signed [NORM_W-1:0]  b_bb_q, b_cc_q;
  logic signed [PROD_W-1:0]  b_p1_q, b_p2_q;
  logic signed [DIFF_W-1:0]  b_dx12_q, b_dy12_q, b_dx23_q, b_dy23_q;
  logic signed [COORD_W-1:0] b_x1_q, b_y1_q;
  // Stage C: determinant and numerator products.
  logic                      c_vld_q;
  logic signed [DET_W-1:0]   c_det_q;
  logic signed [NUMP_W-1:0]  c_mx1_q, c_mx2_q, c_my1_q, c_my2_q;
  logic signed [COORD_W-1:0] c_x1_q, c_y1_q;
  // Stage D: magnitudes and signs.
  logic                      d_vld_q;
  logic [NUM_W-1:0]          d_nx_q, d_ny_q;
  logic [DEN_W-1:0]          d_den_q;
  div_side_t                 d_side_q;

  logic signed [SQ_W-1:0]    x1e, y1e, x2e, y2e, x3e, y3e;
  logic [NORM_W-1:0]         sn1, sn2, sn3;
  logic signed [NUM_W-1:0]   numx, numy;
  logic [DET_W-1:0]          adet;

  assign x1e = SQ_W'(x1_i);
  assign y1e = SQ_W'(y1_i);
  assign x2e = SQ_W'(x2_i);
  assign y2e = SQ_W'(y2_i);
  assign x3e = SQ_W'(x3_i);
  assign y3e = SQ_W'(y3_i);

  assign sn1 = {1'b0, a_sx1_q} + {1'b0, a_sy1_q};
  assign sn2 = {1'b0, a_sx2_q} + {1'b0, a_sy2_q};
  assign sn3 = {1'b0, a_sx3_q} + {1'b0, a_sy3_q};

  assign numx = NUM_W'(c_mx1_q) - NUM_W'(c_mx2_q);
  assign numy = NUM_W'(c_my1_q) - NUM_W'(c_my2_q);
  assign adet = c_det_q[DET_W-1] ? DET_W'(-c_det_q) : DET_W'(c_det_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dx12_q <= DIFF_W'(x1_i) - DIFF_W'(x2_i);
      a_dy12_q <= DIFF_W'(y1_i) - DIFF_W'(y2_i);
      a_dx23_q <= DIFF_W'(x2_i) - DIFF_W'(x3_i);
      a_dy23_q <= DIFF_W'(y2_i) - DIFF_W'(y3_i);
      a_sx1_q  <= x1e * x1e;
      a_sy1_q  <= y1e * y1e;
      a_sx2_q  <= x2e * x2e;
      a_sy2_q  <= y2e * y2e;
      a_sx3_q  <= x3e * x3e;
      a_sy3_q  <= y3e * y3e;
      a_x1_q   <= x1_i;
      a_y1_q   <= y1_i;

      b_bb_q   <= $signed(sn1 - sn2);
      b_cc_q   <= $signed(sn2 - sn3);
      b_p1_q   <= PROD_W'(a_dx12_q) * PROD_W'(a_dy23_q);
      b_p2_q   <= PROD_W'(a_dx23_q) * PROD_W'(a_dy12_q);
      b_dx12_q <= a_dx12_q;
      b_dy12_q <= a_dy12_q;
      b_dx23_q <= a_dx23_q;
      b_dy23_q <= a_dy23_q;
      b_x1_q   <= a_x1_q;
      b_y1_q   <= a_y1_q;

      c_det_q  <= DET_W'(b_p1_q) - DET_W'(b_p2_q);
      c_mx1_q  <= NUMP_W'(b_bb_q) * NUMP_W'(b_dy23_q);
      c_mx2_q  <= NUMP_W'(b_cc_q) * NUMP_W'(b_dy12_q);
      c_my1_q  <= NUMP_W'(b_dx12_q) * NUMP_W'(b_cc_q);
      c_my2_q  <= NUMP_W'(b_dx23_q) * NUMP_W'(b_bb_q);
      c_x1_q   <= b_x1_q;
      c_y1_q   <= b_y1_q;

      d_nx_q         <= numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
      d_ny_q         <= numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
      d_den_q        <= {adet[DET_W-2:0], 1'b0};
      d_side_q.ok    <= (adet != '0) && (adet >= DET_W'(det_min_i));
      d_side_q.neg_x <= numx[NUM_W-1] ^ c_det_q[DET_W-1];
      d_side_q.neg_y <= numy[NUM_W-1] ^ c_det_q[DET_W-1];
      d_side_q.x1    <= c_x1_q;
      d_side_q.y1    <= c_y1_q;
    end
  end

  assign valid_o = d_vld_q;
  assign num_x_o = d_nx_q;
  assign num_y_o = d_ny_q;
  assign den_o   = d_den_q;
  assign side_o  = d_side_q;

endmodule

/* hw/rtl/ctp_div.sv */
// Two-lane restoring divider, one quotient bit per pipeline stage.
module ctp_div import ctp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_x_i,
  input  logic [NUM_W-1:0] num_y_i,
  input  logic [DEN_W-1:0] den_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_x_o,
  output logic [NUM_W-1:0] quot_y_o,
  output div_side_t        side_o
);

  // The numerator register shifts out at the top while quotient bits enter at the bottom.
  logic             vld_q  [NUM_W];
  logic [NUM_W-1:0] nx_q   [NUM_W];
  logic [NUM_W-1:0] ny_q   [NUM_W];
  logic [DEN_W-1:0] rx_q   [NUM_W];
  logic [DEN_W-1:0] ry_q   [NUM_W];
  logic [DEN_W-1:0] den_q  [NUM_W];
  div_side_t        side_q [NUM_W];

  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic             nbit,
                                               input logic [DEN_W-1:0] den);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] df;
    logic           ge;
    sh = {rem, nbit};
    df = sh - {1'b0, den};
    ge = (sh >= {1'b0, den});
    return {ge, ge ? df[DEN_W-1:0] : sh[DEN_W-1:0]};
  endfunction

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic             in_vld;
    logic [NUM_W-1:0] in_nx, in_ny;
    logic [DEN_W-1:0] in_rx, in_ry, in_den;
    div_side_t        in_side;
    logic [DEN_W:0]   step_x, step_y;

    if (g == 0) begin : g_first
      assign in_vld  = valid_i;
      assign in_nx   = num_x_i;
      assign in_ny   = num_y_i;
      assign in_rx   = '0;
      assign in_ry   = '0;
      assign in_den  = den_i;
      assign in_side = side_i;
    end else begin : g_next
      assign in_vld  = vld_q[g-1];
      assign in_nx   = nx_q[g-1];
      assign in_ny   = ny_q[g-1];
      assign in_rx   = rx_q[g-1];
      assign in_ry   = ry_q[g-1];
      assign in_den  = den_q[g-1];
      assign in_side = side_q[g-1];
    end

    assign step_x = div_step(in_rx, in_nx[NUM_W-1], in_den);
    assign step_y = div_step(in_ry, in_ny[NUM_W-1], in_den);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[g]   <= {in_nx[NUM_W-2:0], step_x[DEN_W]};
        ny_q[g]   <= {in_ny[NUM_W-2:0], step_y[DEN_W]};
        rx_q[g]   <= step_x[DEN_W-1:0];
        ry_q[g]   <= step_y[DEN_W-1:0];
        den_q[g]  <= in_den;
        side_q[g] <= in_side;
      end
    end
  end

  assign valid_o  = vld_q[NUM_W-1];
  assign quot_x_o = nx_q[NUM_W-1];
  assign quot_y_o = ny_q[NUM_W-1];
  assign side_o   = side_q[NUM_W-1];

endmodule

/* hw/rtl/ctp_dist.sv */
// Centre saturation, offset from the first point and squared distance.
module ctp_dist import ctp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  quot_x_i,
  input  logic [NUM_W-1:0]  quot_y_i,
  input  div_side_t         side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] sq_dist_o,
  output root_side_t        side_o
);

  logic              e_vld_q, f_vld_q, g_vld_q;
  logic [OUT_W-1:0]  e_cx_q, e_cy_q, e_ux_q, e_uy_q;
  logic              e_ok_q, e_sat_q;
  logic [OUT_W-1:0]  f_cx_q, f_cy_q;
  logic              f_ok_q, f_sat_q;
  logic [ROOT_W-1:0] f_px_q, f_py_q;
  logic [ROOT_W-1:0] g_sum_q;
  root_side_t        g_side_q;

  logic [OUT_W:0]    cx_s, cy_s;
  logic signed [OUT_W:0] ex, ey;
  logic [ROOT_W:0]   sum;

  // Returns the saturation flag above the clipped, signed centre value.
  function automatic logic [OUT_W:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
    logic sat;
    logic [OUT_W-1:0] v;
    if (neg) begin
      sat = (|q[NUM_W-1:OUT_W]) || (q[OUT_W-1] && (|q[OUT_W-2:0]));
      v   = sat ? NEG_MIN : OUT_W'(-q[OUT_W-1:0]);
    end else begin
      sat = |q[NUM_W-1:OUT_W-1];
      v   = sat ? POS_MAX : q[OUT_W-1:0];
    end
    return {sat, v};
  endfunction

  assign cx_s = sat_quot(quot_x_i, side_i.neg_x);
  assign cy_s = sat_quot(quot_y_i, side_i.neg_y);
  assign ex   = $signed({cx_s[OUT_W-1], cx_s[OUT_W-1:0]}) - (OUT_W+1)'(side_i.x1);
  assign ey   = $signed({cy_s[OUT_W-1], cy_s[OUT_W-1:0]}) - (OUT_W+1)'(side_i.y1);
  assign sum  = {1'b0, f_px_q} + {1'b0, f_py_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= valid_i;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_cx_q  <= cx_s[OUT_W-1:0];
      e_cy_q  <= cy_s[OUT_W-1:0];
      e_sat_q <= cx_s[OUT_W] | cy_s[OUT_W];
      e_ok_q  <= side_i.ok;
      // The offset magnitude stays below 2^32, so 32 bits hold it.
      e_ux_q  <= ex[OUT_W] ? OUT_W'(-ex) : ex[OUT_W-1:0];
      e_uy_q  <= ey[OUT_W] ? OUT_W'(-ey) : ey[OUT_W-1:0];

      f_px_q  <= ROOT_W'(e_ux_q) * ROOT_W'(e_ux_q);
      f_py_q  <= ROOT_W'(e_uy_q) * ROOT_W'(e_uy_q);
      f_cx_q  <= e_cx_q;
      f_cy_q  <= e_cy_q;
      f_ok_q  <= e_ok_q;
      f_sat_q <= e_sat_q;

      g_sum_q      <= sum[ROOT_W-1:0];
      g_side_q.ok  <= f_ok_q;
      g_side_q.big <= sum[ROOT_W];
      g_side_q.sat <= f_sat_q | sum[ROOT_W];
      g_side_q.cx  <= f_cx_q;
      g_side_q.cy  <= f_cy_q;
    end
  end

  assign valid_o   = g_vld_q;
  assign sq_dist_o = g_sum_q;
  assign side_o    = g_side_q;

endmodule

/* hw/rtl/ctp_sqrt.sv */
// Floor square root, one result bit per pipeline stage.
module ctp_sqrt import ctp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] value_i,
  input  root_side_t        side_i,
  output logic              valid_o,
  output logic [OUT_W-1:0]  root_o,
  output root_side_t        side_o
);

  logic              vld_q  [OUT_W];
  logic [ROOT_W-1:0] rem_q  [OUT_W];
  logic [ROOT_W-1:0] res_q  [OUT_W];
  root_side_t        side_q [OUT_W];

  for (genvar g = 0; g < OUT_W; g++) begin : g_stage
    localparam logic [ROOT_W-1:0] BitW = ROOT_W'(1) << (ROOT_W - 2 - 2 * g);
    logic              in_vld;
    logic [ROOT_W-1:0] in_rem, in_res;
    root_side_t        in_side;
    logic [ROOT_W:0]   trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign in_vld  = valid_i;
      assign in_rem  = value_i;
      assign in_res  = '0;
      assign in_side = side_i;
    end else begin : g_next
      assign in_vld  = vld_q[g-1];
      assign in_rem  = rem_q[g-1];
      assign in_res  = res_q[g-1];
      assign in_side = side_q[g-1];
    end

    assign trial = {1'b0, in_res} + {1'b0, BitW};
    assign ge    = {1'b0, in_rem} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? in_rem - trial[ROOT_W-1:0] : in_rem;
        res_q[g]  <= ge ? (in_res >> 1) + BitW : in_res >> 1;
        side_q[g] <= in_side;
      end
    end
  end

  assign valid_o = vld_q[OUT_W-1];
  assign root_o  = res_q[OUT_W-1][OUT_W-1:0];
  assign side_o  = side_q[OUT_W-1];

endmodule

/* hw/rtl/circle_through_three_points.sv */
// Top level: circle through three points, centre and radius, fully pipelined.
//
// Usage. Three points arrive as one item on the slave stream (s_axis_*), six
// signed 20-bit coordinates with four fraction bits. Each item yields exactly
// one result item on the master stream (m_axis_*): the centre of the circle
// through the points and its floor radius, plus flags for collinear points
// and for clipping. The collinearity threshold is written through the cfg_*
// channel, which is always ready; write it only while no item is in flight.
// Throughput is one item per clock while results are taken. The stages are four
// front stages (differences, norms, determinant, numerators), 63 divider stages
// that each settle one quotient bit of both centre coordinates, three distance
// stages, 32 square-root stages that each settle one radius bit, and the output
// register. The divider depth is set by the 63-bit numerator.
// Reset empties the pipeline and sets the threshold to one. When the receiver
// stalls with a result waiting, the whole pipeline holds and s_axis_tready_o
// drops; nothing is lost or repeated, and it moves on as soon as the result
// is taken.
module circle_through_three_points import ctp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Fields from bit 0: first_x, first_y, second_x, second_y, third_x, third_y.
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // Fields from bit 0: centre_x, centre_y, radius.
  output logic [DATA_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: circle_ok, saturated.
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  logic [DMIN_W-1:0] cfg_data_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o
);

  logic              en;
  logic [DMIN_W-1:0] det_min_q;

  logic              front_vld;
  logic [NUM_W-1:0]  front_nx, front_ny;
  logic [DEN_W-1:0]  front_den;
  div_side_t         front_side;

  logic              div_vld;
  logic [NUM_W-1:0]  div_qx, div_qy;
  div_side_t         div_side;

  logic              dist_vld;
  logic [ROOT_W-1:0] dist_sq;
  root_side_t        dist_side;

  logic              root_vld;
  logic [OUT_W-1:0]  root_val;
  root_side_t        root_side;

  logic              out_vld_q;
  logic [DATA_W-1:0] out_data_q;
  logic [1:0]        out_user_q;
  logic [OUT_W-1:0]  radius;

  // One enable moves every stage; it is held only while a result waits untaken.
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_min_q <= DET_MIN_RST;
    end else if (cfg_valid_i) begin
      det_min_q <= cfg_data_i;
    end
  end

  ctp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid_i),
    .x1_i      ($signed(s_axis_tdata_i[0*COORD_W +: COORD_W])),
    .y1_i      ($signed(s_axis_tdata_i[1*COORD_W +: COORD_W])),
    .x2_i      ($signed(s_axis_tdata_i[2*COORD_W +: COORD_W])),
    .y2_i      ($signed(s_axis_tdata_i[3*COORD_W +: COORD_W])),
    .x3_i      ($signed(s_axis_tdata_i[4*COORD_W +: COORD_W])),
    .y3_i      ($signed(s_axis_tdata_i[5*COORD_W +: COORD_W])),
    .det_min_i (det_min_q),
    .valid_o   (front_vld),
    .num_x_o   (front_nx),
    .num_y_o   (front_ny),
    .den_o     (front_den),
    .side_o    (front_side)
  );

  ctp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (front_vld),
    .num_x_i  (front_nx),
    .num_y_i  (front_ny),
    .den_i    (front_den),
    .side_i   (front_side),
    .valid_o  (div_vld),
    .quot_x_o (div_qx),
    .quot_y_o (div_qy),
    .side_o   (div_side)
  );

  ctp_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (div_vld),
    .quot_x_i  (div_qx),
    .quot_y_i  (div_qy),
    .side_i    (div_side),
    .valid_o   (dist_vld),
    .sq_dist_o (dist_sq),
    .side_o    (dist_side)
  );

  ctp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dist_vld),
    .value_i (dist_sq),
    .side_i  (dist_side),
    .valid_o (root_vld),
    .root_o  (root_val),
    .side_o  (root_side)
  );

  // A squared distance of 2^64 or more clips the radius to all ones.
  assign radius = root_side.big ? RAD_MAX : root_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= root_vld;
    end
  end

  // Collinear points give a result of all zeros apart from the valid.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (root_side.ok) begin
        out_data_q <= {radius, root_side.cy, root_side.cx};
        out_user_q <= {root_side.sat, 1'b1};
      end else begin
        out_data_q <= '0;
        out_user_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTH
  a_collinear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && !m_axis_tuser_o[1])
    else $error("collinear result carries non-zero fields");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(front_vld))
    else $error("front pipeline moved during a stall");

  a_root_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(root_vld) && $stable(root_val))
    else $error("square-root pipeline moved during a stall");
`endif

endmodule
